[hdl/mgs_pkg.sv]
// Shared constants and controller/datapath handshake types for the mean gradient block.
package mgs_pkg;

	localparam int MAX_WIDTH   = 2048;
	localparam int MAX_HEIGHT  = 2048;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int ROW_W       = $clog2(MAX_HEIGHT);
	localparam int FILL_W      = COL_W + 1;
	localparam int PIX_W       = 8;
	localparam int CFG_W       = 12;
	localparam int CFG_IDX_W   = 1;
	localparam int OUT_W       = 16;
	localparam int SUM_W       = 39;
	localparam int DEN_W       = COL_W + ROW_W;
	localparam int SQ_W        = 2 * PIX_W + 1;
	localparam int FRAC_SHIFT  = 15;
	localparam int RAD_W       = SQ_W + FRAC_SHIFT;
	localparam int ROOT_W      = RAD_W / 2;
	localparam int SQRT_STEPS  = ROOT_W;
	localparam int SQRT_CNT_W  = $clog2(SQRT_STEPS);
	localparam int DIV_STEPS   = SUM_W;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

	localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
	localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic accept;
		logic diff;
		logic sqrt_step;
		logic acc;
		logic div_start;
		logic div_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic grad_en;
		logic frame_end;
		logic sqrt_done;
		logic div_done;
	} status_t;

endpackage

[hdl/mgs_pixel_if.sv]
// Pixel input channel: valid/ready handshake with an 8-bit grayscale word.
interface mgs_pixel_if;
	logic                      valid;
	logic                      ready;
	logic [mgs_pkg::PIX_W-1:0] pixel;

	modport source (output valid, output pixel, input ready);
	modport sink   (input valid, input pixel, output ready);
endinterface

[hdl/mgs_result_if.sv]
// Result output channel: valid/ready handshake with a 16-bit Q8.8 mean gradient word.
interface mgs_result_if;
	logic                      valid;
	logic                      ready;
	logic [mgs_pkg::OUT_W-1:0] mean_gradient;

	modport source (output valid, output mean_gradient, input ready);
	modport sink   (input valid, input mean_gradient, output ready);
endinterface

[hdl/mgs_datapath.sv]
// Datapath: config registers, line memory, position counters, square root, sum and divider.
module mgs_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [mgs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mgs_pkg::CFG_W-1:0]     cfg_data,
	input  logic [mgs_pkg::PIX_W-1:0]     pixel,
	input  mgs_pkg::cmd_t                 cmd,
	output mgs_pkg::status_t              st,
	output logic [mgs_pkg::OUT_W-1:0]     mean_gradient
);
	import mgs_pkg::*;

	logic [CFG_W-1:0]  width_q, height_q;
	logic [COL_W-1:0]  wm1, col_q, col_p1;
	logic [ROW_W-1:0]  hm1, row_q;
	logic [FILL_W-1:0] fill_q;
	logic              last_col, last_row;

	logic [PIX_W-1:0]  line_mem [MAX_WIDTH];
	logic [PIX_W-1:0]  here_raw_q, right_raw_q, px_q;
	logic              here_vld_q, right_vld_q;
	logic              grad_en_q, frame_end_q;
	logic [DEN_W-1:0]  den_q;

	logic [PIX_W-1:0]        here_px, right_px;
	logic signed [PIX_W:0]   dx, dy;
	logic signed [2*PIX_W+1:0] dx2, dy2;
	logic [SQ_W-1:0]         sq_sum;

	logic [RAD_W-1:0]      rad_q;
	logic [ROOT_W-1:0]     root_q;
	logic [ROOT_W:0]       srem_q;
	logic [ROOT_W+2:0]     srem_sh;
	logic [ROOT_W+1:0]     strial;
	logic [SQRT_CNT_W-1:0] sq_cnt_q;

	logic [SUM_W-1:0]     sum_q, sum_next;
	logic [SUM_W-1:0]     quo_q;
	logic [DEN_W-1:0]     drem_q;
	logic [DEN_W:0]       drem_sh;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	// Clamp the frame size to the supported range; keep size minus one.
	always_comb begin
		if (width_q < CFG_W'(2))
			wm1 = COL_W'(1);
		else if (width_q > CFG_W'(MAX_WIDTH))
			wm1 = COL_W'(MAX_WIDTH - 1);
		else
			wm1 = COL_W'(width_q - CFG_W'(1));
		if (height_q < CFG_W'(2))
			hm1 = ROW_W'(1);
		else if (height_q > CFG_W'(MAX_HEIGHT))
			hm1 = ROW_W'(MAX_HEIGHT - 1);
		else
			hm1 = ROW_W'(height_q - CFG_W'(1));
	end

	assign last_col = col_q >= wm1;
	assign last_row = row_q >= hm1;
	assign col_p1   = col_q + COL_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Position counters and fill mark of the line memory.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			fill_q      <= '0;
			grad_en_q   <= 1'b0;
			frame_end_q <= 1'b0;
			here_vld_q  <= 1'b0;
			right_vld_q <= 1'b0;
		end else if (cmd.accept) begin
			grad_en_q   <= (row_q != '0) && !last_col;
			frame_end_q <= last_col && last_row;
			here_vld_q  <= {1'b0, col_q} < fill_q;
			right_vld_q <= ({1'b0, col_q} + FILL_W'(1)) < fill_q;
			if ({1'b0, col_q} >= fill_q)
				fill_q <= {1'b0, col_q} + FILL_W'(1);
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_p1;
			end
		end
	end

	// Line memory: read old row at the column and its right neighbor, write new pixel.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			here_raw_q   <= line_mem[col_q];
			right_raw_q  <= line_mem[col_p1];
			line_mem[col_q] <= pixel;
			px_q         <= pixel;
			den_q        <= DEN_W'(wm1) * DEN_W'(hm1);
		end
	end

	// Entries beyond the fill mark read as zero.
	always_comb begin
		here_px  = here_vld_q ? here_raw_q : '0;
		right_px = right_vld_q ? right_raw_q : '0;
		dx       = $signed({1'b0, right_px}) - $signed({1'b0, here_px});
		dy       = $signed({1'b0, px_q}) - $signed({1'b0, here_px});
		dx2      = dx * dx;
		dy2      = dy * dy;
		sq_sum   = SQ_W'(dx2) + SQ_W'(dy2);
	end

	// Restoring square root, one result bit per step.
	assign srem_sh = {srem_q, rad_q[RAD_W-1 -: 2]};
	assign strial  = {root_q, 2'b01};

	always_ff @(posedge clk) begin
		if (cmd.diff) begin
			rad_q  <= {sq_sum, FRAC_SHIFT'(0)};
			root_q <= '0;
			srem_q <= '0;
		end else if (cmd.sqrt_step) begin
			rad_q <= {rad_q[RAD_W-3:0], 2'b00};
			if (srem_sh >= {1'b0, strial}) begin
				srem_q <= (ROOT_W+1)'(srem_sh - {1'b0, strial});
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				srem_q <= (ROOT_W+1)'(srem_sh);
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sq_cnt_q <= '0;
		else if (cmd.diff)
			sq_cnt_q <= '0;
		else if (cmd.sqrt_step)
			sq_cnt_q <= sq_cnt_q + SQRT_CNT_W'(1);
	end

	// Running sum wraps at its width; frame end hands it to the divider and clears.
	assign sum_next = cmd.acc ? sum_q + SUM_W'(root_q) : sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sum_q <= '0;
		else if (cmd.div_start)
			sum_q <= '0;
		else
			sum_q <= sum_next;
	end

	// Restoring divider, one quotient bit per step.
	assign drem_sh = {drem_q, quo_q[SUM_W-1]};

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			quo_q  <= sum_next;
			drem_q <= '0;
		end else if (cmd.div_step) begin
			if (drem_sh >= {1'b0, den_q}) begin
				drem_q <= DEN_W'(drem_sh - {1'b0, den_q});
				quo_q  <= {quo_q[SUM_W-2:0], 1'b1};
			end else begin
				drem_q <= DEN_W'(drem_sh);
				quo_q  <= {quo_q[SUM_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			div_cnt_q <= '0;
		else if (cmd.div_start)
			div_cnt_q <= '0;
		else if (cmd.div_step)
			div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
	end

	// Saturate the quotient into the output word.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			if (quo_q[SUM_W-1:OUT_W] != '0)
				mean_gradient <= '1;
			else
				mean_gradient <= quo_q[OUT_W-1:0];
		end
	end

	assign st.grad_en   = grad_en_q;
	assign st.frame_end = frame_end_q;
	assign st.sqrt_done = sq_cnt_q == SQRT_CNT_W'(SQRT_STEPS - 1);
	assign st.div_done  = div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1);

endmodule

[hdl/mgs_controller.sv]
// Controller: sequences one pixel word at a time through the datapath and owns the output valid.
module mgs_controller (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  mgs_pkg::status_t st,
	output mgs_pkg::cmd_t    cmd
);
	import mgs_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_DIFF = 6'b000010,
		ST_SQRT = 6'b000100,
		ST_ACC  = 6'b001000,
		ST_DIV  = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	state_t state_q, state_next;
	logic   out_valid_q;

	always_comb begin
		cmd        = '0;
		in_ready   = 1'b0;
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_next = ST_DIFF;
				end
			end
			ST_DIFF: begin
				if (st.grad_en) begin
					cmd.diff   = 1'b1;
					state_next = ST_SQRT;
				end else if (st.frame_end) begin
					cmd.div_start = 1'b1;
					state_next    = ST_DIV;
				end else begin
					state_next = ST_IDLE;
				end
			end
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (st.sqrt_done)
					state_next = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				if (st.frame_end) begin
					cmd.div_start = 1'b1;
					state_next    = ST_DIV;
				end else begin
					state_next = ST_IDLE;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (st.div_done)
					state_next = ST_OUT;
			end
			ST_OUT: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_next   = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

[hdl/mean_gradient_sharpness.sv]
// Top level of the mean gradient sharpness block: controller plus datapath.
//
// Usage:
//   pixel_ch carries a grayscale frame in raster order, one 8-bit word per pixel.
//   result_ch carries one 16-bit unsigned Q8.8 word per frame: the mean of
//   sqrt((dx^2+dy^2)/2) over all pixels not in the last row or column.
//   cfg_write/cfg_index/cfg_data set image_width (index 0) and image_height
//   (index 1); write them only between frames while the block is idle.
//
// Sequence per pixel:
//   A pixel that has no gradient (first row, last column) is stored and the block returns to idle.
//   A pixel that closes a gradient goes through memory read, squares,
//   16 steps of the bit-serial square root, and accumulate.
//   The last pixel of a frame adds 39 steps of the bit-serial divider and
//   a load of the output register.
//
// Reset clears the position counters, the running sum and the line memory
// fill mark (unwritten line entries read as zero), and restores 640x480.
// While the receiver stalls, the finished word waits in the output register
// and pixels keep flowing; only the next frame result waits for it to leave.
module mean_gradient_sharpness (
	input  logic                          clk,
	input  logic                          arst_n,
	mgs_pixel_if.sink                     pixel_ch,
	mgs_result_if.source                  result_ch,
	input  logic                          cfg_write,
	input  logic [mgs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mgs_pkg::CFG_W-1:0]     cfg_data
);
	import mgs_pkg::*;

	cmd_t    cmd;
	status_t st;

	// Sequence each pixel word and own the result handshake.
	mgs_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pixel_ch.valid),
		.in_ready  (pixel_ch.ready),
		.out_valid (result_ch.valid),
		.out_ready (result_ch.ready),
		.st        (st),
		.cmd       (cmd)
	);

	// Line memory, square root, running sum and divider.
	mgs_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.pixel         (pixel_ch.pixel),
		.cmd           (cmd),
		.st            (st),
		.mean_gradient (result_ch.mean_gradient)
	);

endmodule
